/* src/line_pixel_stepper_macros.svh */
// assertion macros used by the line pixel stepper checker
`ifndef LINE_PIXEL_STEPPER_MACROS_SVH
`define LINE_PIXEL_STEPPER_MACROS_SVH

// checked at every clock edge, reset included
`define LPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// checked only while out of reset
`define LPS_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

/* src/lps_pkg.sv */
// shared types and constants of the line pixel stepper
package lps_pkg;

  localparam int COORD_BITS    = 12;
  localparam int ERR_BITS      = COORD_BITS + 3;
  localparam int FW_BITS       = 13;
  localparam int BPP_BITS      = 3;
  localparam int STRIDE_BITS   = FW_BITS + BPP_BITS;
  localparam int ADDR_BITS     = 26;
  localparam int PROD_BITS     = COORD_BITS + STRIDE_BITS + 1;
  localparam int SUM_BITS      = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;
  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + ADDR_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [FW_BITS-1:0]  FW_RESET  = FW_BITS'(640);
  localparam logic [BPP_BITS-1:0] BPP_RESET = BPP_BITS'(3);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic {
    REG_FRAME_WIDTH     = 1'b0,
    REG_BYTES_PER_PIXEL = 1'b1
  } reg_e;

  typedef logic [COORD_BITS-1:0] coord_t;

  // classified word handed from front to back
  typedef struct packed {
    op_e    op;
    logic   steep;
    coord_t major_start;
    coord_t minor_start;
    coord_t major_end;
    coord_t delta_major;
    coord_t delta_minor;
    logic   minor_down;
  } cmd_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t x;
    coord_t y;
  } pix_t;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    coord_t               x;
    coord_t               y;
    logic [ADDR_BITS-1:0] addr;
  } res_t;

  typedef struct packed {
    logic [FW_BITS-1:0]  frame_width;
    logic [BPP_BITS-1:0] bytes_per_pixel;
  } cfg_t;

endpackage

/* src/lps_front.sv */
// front end: accepts words and works out the line setup of load words
module lps_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lps_pkg::op_e  in_op_i,
  input  logic [lps_pkg::IN_DATA_BITS-1:0] in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output lps_pkg::cmd_t cmd_o
);

  localparam int C = lps_pkg::COORD_BITS;

  lps_pkg::coord_t x0, y0, x1, y1;
  lps_pkg::coord_t adx, ady, a0, b0, a1, b1, minor_other;
  logic            x_rev, y_rev, steep, rev;
  lps_pkg::cmd_t   cmd_d, cmd_q;
  logic            valid_d, valid_q;
  logic            in_fire;

  assign x0 = in_data_i[C-1:0];
  assign y0 = in_data_i[2*C-1:C];
  assign x1 = in_data_i[3*C-1:2*C];
  assign y1 = in_data_i[4*C-1:3*C];

  always_comb begin
    x_rev = x0 > x1;
    y_rev = y0 > y1;
    adx   = x_rev ? (x0 - x1) : (x1 - x0);
    ady   = y_rev ? (y0 - y1) : (y1 - y0);
    steep = ady > adx;
    if (steep) begin
      a0  = y0;
      b0  = x0;
      a1  = y1;
      b1  = x1;
      rev = y_rev;
    end else begin
      a0  = x0;
      b0  = y0;
      a1  = x1;
      b1  = y1;
      rev = x_rev;
    end
    // order endpoints so the major coordinate rises
    cmd_d.op          = in_op_i;
    cmd_d.steep       = steep;
    cmd_d.major_start = rev ? a1 : a0;
    cmd_d.minor_start = rev ? b1 : b0;
    cmd_d.major_end   = rev ? a0 : a1;
    minor_other       = rev ? b0 : b1;
    cmd_d.delta_major = steep ? ady : adx;
    cmd_d.delta_minor = steep ? adx : ady;
    cmd_d.minor_down  = !(cmd_d.minor_start < minor_other);
  end

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* src/lps_queue.sv */
// short queue of classified words between front and back
module lps_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lps_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          not_empty_o,
  output lps_pkg::cmd_t pop_data_o
);

  localparam int D = lps_pkg::QUEUE_DEPTH;

  lps_pkg::cmd_t                  entry_q [D];
  logic [lps_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [lps_pkg::QCNT_BITS-1:0] count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o      = count_q == lps_pkg::QCNT_BITS'(D);
  assign not_empty_o = count_q != '0;
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == lps_pkg::QPTR_BITS'(D - 1)) ? '0
               : wr_ptr_q + lps_pkg::QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == lps_pkg::QPTR_BITS'(D - 1)) ? '0
               : rd_ptr_q + lps_pkg::QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + lps_pkg::QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - lps_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/lps_back.sv */
// back end: bresenham stepper, address stage and output register
module lps_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lps_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  lps_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lps_pkg::res_t out_o
);

  localparam int C  = lps_pkg::COORD_BITS;
  localparam int EB = lps_pkg::ERR_BITS;
  localparam int SB = lps_pkg::SUM_BITS;

  // line state
  logic                   active_q, active_d;
  logic                   steep_q, steep_d;
  lps_pkg::coord_t        major_pos_q, major_pos_d, minor_pos_q, minor_pos_d;
  lps_pkg::coord_t        major_end_q, major_end_d;
  lps_pkg::coord_t        delta_major_q, delta_major_d, delta_minor_q, delta_minor_d;
  logic                   minor_down_q, minor_down_d;
  logic signed [EB-1:0]   err_q, err_d;

  logic signed [EB-1:0]   dmin2, dmaj2, load_dmin2, load_dmaj;
  logic [C:0]             major_inc;
  logic                   is_last;
  logic                   adv_out, adv_p1, head_step, step_fire, load_fire;

  lps_pkg::pix_t          pix_d, p1_q;
  logic                   p1_valid_q;
  logic [lps_pkg::STRIDE_BITS-1:0] stride_q;
  logic [SB-1:0]          addr_full;
  lps_pkg::res_t          res_q;
  logic                   out_valid_q;

  // row stride follows the registers, which the user changes only while idle; the block does not enforce it
  always_ff @(posedge clk_i) begin
    stride_q <= lps_pkg::STRIDE_BITS'(cfg_i.frame_width)
              * lps_pkg::STRIDE_BITS'(cfg_i.bytes_per_pixel);
  end

  assign adv_out   = !out_valid_q || out_ready_i;
  assign adv_p1    = !p1_valid_q || adv_out;
  assign head_step = cmd_i.op == lps_pkg::OP_STEP;
  // loads only touch line state, so they drain even when the output stalls
  assign cmd_pop_o = cmd_valid_i && (!head_step || adv_p1);
  assign step_fire = cmd_pop_o && head_step;
  assign load_fire = cmd_pop_o && !head_step;

  assign dmin2      = signed'({2'b00, delta_minor_q, 1'b0});
  assign dmaj2      = signed'({2'b00, delta_major_q, 1'b0});
  assign load_dmin2 = signed'({2'b00, cmd_i.delta_minor, 1'b0});
  assign load_dmaj  = signed'({3'b000, cmd_i.delta_major});
  assign major_inc  = {1'b0, major_pos_q} + (C + 1)'(1);
  assign is_last    = major_inc == {1'b0, major_end_q};

  always_comb begin
    active_d      = active_q;
    steep_d       = steep_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_end_d   = major_end_q;
    delta_major_d = delta_major_q;
    delta_minor_d = delta_minor_q;
    minor_down_d  = minor_down_q;
    err_d         = err_q;
    pix_d         = '0;
    if (load_fire) begin
      steep_d       = cmd_i.steep;
      major_pos_d   = cmd_i.major_start;
      minor_pos_d   = cmd_i.minor_start;
      major_end_d   = cmd_i.major_end;
      delta_major_d = cmd_i.delta_major;
      delta_minor_d = cmd_i.delta_minor;
      minor_down_d  = cmd_i.minor_down;
      err_d         = load_dmin2 - load_dmaj;
      active_d      = cmd_i.delta_major != '0;
    end else if (step_fire && active_q) begin
      pix_d.valid = 1'b1;
      pix_d.last  = is_last;
      pix_d.x     = steep_q ? minor_pos_q : major_pos_q;
      pix_d.y     = steep_q ? major_pos_q : minor_pos_q;
      if (err_q <= 0) begin
        err_d = err_q + dmin2;
      end else begin
        err_d       = err_q + dmin2 - dmaj2;
        minor_pos_d = minor_down_q ? (minor_pos_q - lps_pkg::coord_t'(1))
                                   : (minor_pos_q + lps_pkg::coord_t'(1));
      end
      major_pos_d = major_inc[C-1:0];
      if (is_last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      steep_q       <= 1'b0;
      major_pos_q   <= '0;
      minor_pos_q   <= '0;
      major_end_q   <= '0;
      delta_major_q <= '0;
      delta_minor_q <= '0;
      minor_down_q  <= 1'b0;
      err_q         <= '0;
      p1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      active_q      <= active_d;
      steep_q       <= steep_d;
      major_pos_q   <= major_pos_d;
      minor_pos_q   <= minor_pos_d;
      major_end_q   <= major_end_d;
      delta_major_q <= delta_major_d;
      delta_minor_q <= delta_minor_d;
      minor_down_q  <= minor_down_d;
      err_q         <= err_d;
      if (adv_p1) begin
        p1_valid_q <= step_fire;
      end
      if (adv_out) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  // byte address: y * stride + x * bytes_per_pixel, wrapped to the address width
  assign addr_full = SB'(p1_q.y) * SB'(stride_q)
                   + SB'(p1_q.x) * SB'(cfg_i.bytes_per_pixel);

  always_ff @(posedge clk_i) begin
    if (adv_p1) begin
      p1_q <= pix_d;
    end
    if (adv_out) begin
      res_q.valid <= p1_q.valid;
      res_q.last  <= p1_q.last;
      res_q.x     <= p1_q.x;
      res_q.y     <= p1_q.y;
      res_q.addr  <= addr_full[lps_pkg::ADDR_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

/* src/line_pixel_stepper.sv */
// top level of the line pixel stepper: stream ports, register file, front, queue, back
// Bresenham line stepper. A load word (tuser 0) sets up a line between two
// endpoints and gives no result; each step word (tuser 1) gives one result word:
// the next pixel's x, y and framebuffer byte address, tlast on the final pixel,
// and result tuser 1, or tuser 0 with all-zero data when no line is active. The
// far endpoint is never emitted and a zero-length line emits nothing. One word
// is taken per clock while the result side keeps up: the back-end stepper
// updates its error term and position once per cycle, which sets that figure.
// A step word's result passes the front register, queue, step stage and
// address stage. A two-entry queue lets loads and steps keep arriving while
// the result side stalls. Registers frame_width (0x0) and bytes_per_pixel (0x4)
// are written over APB, by the user only while idle; the block does not enforce it.
module line_pixel_stepper (
  input  logic clk_i,
  input  logic rst_ni,
  // stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lps_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,  // start_x, start_y, end_x, end_y
  input  logic                              s_axis_tuser,  // operation
  // stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lps_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,  // pixel_x, pixel_y, byte_address
  output logic                              m_axis_tuser,  // pixel_valid
  output logic                              m_axis_tlast,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lps_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lps_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lps_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  logic [lps_pkg::FW_BITS-1:0]  frame_width_q;
  logic [lps_pkg::BPP_BITS-1:0] bytes_per_pixel_q;
  lps_pkg::reg_e                reg_sel;
  logic                         reg_write;
  lps_pkg::cfg_t                cfg;

  logic          front_valid, queue_full, queue_not_empty, queue_pop;
  lps_pkg::cmd_t front_cmd, queue_cmd;
  lps_pkg::res_t res;

  assign pready    = 1'b1;
  assign reg_sel   = lps_pkg::reg_e'(paddr[2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q     <= lps_pkg::FW_RESET;
      bytes_per_pixel_q <= lps_pkg::BPP_RESET;
    end else if (reg_write) begin
      unique case (reg_sel)
        lps_pkg::REG_FRAME_WIDTH: begin
          frame_width_q <= pwdata[lps_pkg::FW_BITS-1:0];
        end
        lps_pkg::REG_BYTES_PER_PIXEL: begin
          bytes_per_pixel_q <= pwdata[lps_pkg::BPP_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lps_pkg::REG_FRAME_WIDTH:     prdata = lps_pkg::APB_DATA_BITS'(frame_width_q);
      lps_pkg::REG_BYTES_PER_PIXEL: prdata = lps_pkg::APB_DATA_BITS'(bytes_per_pixel_q);
      default:                      prdata = '0;
    endcase
  end

  assign cfg.frame_width     = frame_width_q;
  assign cfg.bytes_per_pixel = bytes_per_pixel_q;

  lps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (lps_pkg::op_e'(s_axis_tuser)),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (!queue_full),
    .cmd_o       (front_cmd)
  );

  lps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .not_empty_o (queue_not_empty),
    .pop_data_o  (queue_cmd)
  );

  lps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (queue_not_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = lps_pkg::OUT_DATA_BITS'({res.addr, res.y, res.x});
  assign m_axis_tuser = res.valid;
  assign m_axis_tlast = res.last;

endmodule

/* src/lps_checker.sv */
// port-level checks of the line pixel stepper and their bind
`include "line_pixel_stepper_macros.svh"

module lps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lps_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tlast,
  input logic [lps_pkg::APB_DATA_BITS-1:0] prdata,
  input logic                              pready
);

  // a stalled result word holds
  `LPS_ASSERT_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

  // an idle step gives all-zero data and no last flag
  `LPS_ASSERT_RUN(a_idle_zero, m_axis_tvalid && !m_axis_tuser |-> !m_axis_tlast && (m_axis_tdata == '0), "idle result carries data")

  // register reads never show bits above the frame width field
  `LPS_ASSERT_RUN(a_prdata_width, (prdata >> lps_pkg::FW_BITS) == '0, "register read wider than its field")

  // the register port never waits
  `LPS_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (.*);
